### design/pip_pkg.sv
// ----------------------------------------------------------------------------
// pip_pkg: shared definitions for the point-in-polygon block
// Sizes, command codes, controller states and the control and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package pip_pkg;

	// Table depth and the widths that follow from it.
	localparam int MAX_VERTICES = 64;
	localparam int IDX_W        = $clog2(MAX_VERTICES);

	// Fixed field widths.
	localparam int CNT_W   = 7;
	localparam int SLOT_W  = 6;
	localparam int COORD_W = 16;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int PROD_W  = 2 * DIFF_W;

	// Cycles between the last table read and a settled parity bit.
	localparam int DRAIN_CYC = 3;
	localparam int DRAIN_W   = $clog2(DRAIN_CYC);

	// Input command codes.
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_WALK,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             wr_en;
		logic             query_start;
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             load_prev;
		logic             edge_rd;
		logic             out_load;
	} ctrl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic             cnt_zero;
		logic [IDX_W-1:0] last_idx;
		logic             out_full;
	} stat_t;

endpackage

### design/pip_ctrl.sv
// ----------------------------------------------------------------------------
// pip_ctrl: sequencer for the point-in-polygon block
// Accepts beats, steps the vertex read address through the edge walk,
// waits for the datapath pipeline to drain and loads the result register once it is free.
// ----------------------------------------------------------------------------
module pip_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           cmd,
	input  logic           out_stall,
	input  pip_pkg::stat_t stat,
	output logic           in_stall,
	output pip_pkg::ctrl_t ctrl
);

	pip_pkg::state_t                state_q, state_d;
	logic [pip_pkg::IDX_W-1:0]      idx_q;
	logic [pip_pkg::DRAIN_W-1:0]    drain_q;
	logic                           accept;
	logic                           walk_last;
	logic                           drain_last;
	logic                           out_free;

	assign in_stall   = (state_q != pip_pkg::ST_IDLE);
	assign accept     = in_valid && !in_stall;
	assign walk_last  = (idx_q == stat.last_idx);
	assign drain_last = (drain_q == pip_pkg::DRAIN_W'(pip_pkg::DRAIN_CYC - 1));
	assign out_free   = !stat.out_full || !out_stall;

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			pip_pkg::ST_IDLE: begin
				if (accept && (cmd == pip_pkg::CMD_QUERY)) begin
					state_d = stat.cnt_zero ? pip_pkg::ST_FINISH : pip_pkg::ST_LOAD;
				end
			end
			pip_pkg::ST_LOAD: begin
				state_d = pip_pkg::ST_WALK;
			end
			pip_pkg::ST_WALK: begin
				if (walk_last) begin
					state_d = pip_pkg::ST_DRAIN;
				end
			end
			pip_pkg::ST_DRAIN: begin
				if (drain_last) begin
					state_d = pip_pkg::ST_FINISH;
				end
			end
			pip_pkg::ST_FINISH: begin
				if (out_free) begin
					state_d = pip_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pip_pkg::ST_IDLE;
			end
		endcase
	end

	// Command outputs.
	always_comb begin
		ctrl = '0;
		case (state_q)
			pip_pkg::ST_IDLE: begin
				ctrl.wr_en       = accept && (cmd == pip_pkg::CMD_WRITE);
				ctrl.query_start = accept && (cmd == pip_pkg::CMD_QUERY);
			end
			pip_pkg::ST_LOAD: begin
				ctrl.rd_en     = 1'b1;
				ctrl.rd_addr   = stat.last_idx;
				ctrl.load_prev = 1'b1;
			end
			pip_pkg::ST_WALK: begin
				ctrl.rd_en   = 1'b1;
				ctrl.rd_addr = idx_q;
				ctrl.edge_rd = 1'b1;
			end
			pip_pkg::ST_DRAIN: begin
				ctrl = '0;
			end
			pip_pkg::ST_FINISH: begin
				ctrl.out_load = out_free;
			end
			default: begin
				ctrl = '0;
			end
		endcase
	end

	// State register plus the walk and drain counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pip_pkg::ST_IDLE;
			idx_q   <= '0;
			drain_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == pip_pkg::ST_LOAD) begin
				idx_q <= '0;
			end else if (state_q == pip_pkg::ST_WALK) begin
				idx_q <= idx_q + 1'b1;
			end
			if (state_q == pip_pkg::ST_DRAIN) begin
				drain_q <= drain_q + 1'b1;
			end else begin
				drain_q <= '0;
			end
		end
	end

endmodule

### design/pip_dp.sv
// ----------------------------------------------------------------------------
// pip_dp: datapath for the point-in-polygon block
// Vertex table, vertex count register, a three-stage edge crossing pipe
// (differences, products, compare) with the parity bit, and the result
// register.
// ----------------------------------------------------------------------------
module pip_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pip_pkg::CNT_W-1:0]           cfg_wdata,
	input  logic [pip_pkg::SLOT_W-1:0]          vertex_index,
	input  logic signed [pip_pkg::COORD_W-1:0]  coord_x,
	input  logic signed [pip_pkg::COORD_W-1:0]  coord_y,
	input  logic                                out_stall,
	input  pip_pkg::ctrl_t                      ctrl,
	output pip_pkg::stat_t                      stat,
	output logic                                out_valid,
	output logic                                inside_res
);

	// Vertex table, x in the upper half and y in the lower half.
	logic [2*pip_pkg::COORD_W-1:0] vtx_mem [pip_pkg::MAX_VERTICES];

	logic [pip_pkg::CNT_W-1:0]          vertex_count_q;
	logic [pip_pkg::CNT_W-1:0]          n_eff;
	logic signed [pip_pkg::COORD_W-1:0] px_q, py_q;
	logic signed [pip_pkg::COORD_W-1:0] ax_q, ay_q;
	logic signed [pip_pkg::COORD_W-1:0] bx_s1, by_s1;
	logic                               load_s1, edge_s1;
	logic signed [pip_pkg::DIFF_W-1:0]  dxp_s2, dy_s2, dyp_s2, dbx_s2;
	logic                               up_s2, span_s2, edge_s2;
	logic signed [pip_pkg::PROD_W-1:0]  lhs_s3, rhs_s3;
	logic                               up_s3, span_s3, edge_s3;
	logic                               parity_q;
	logic                               out_valid_q, inside_q;
	logic                               slot_ok;
	logic                               up_c, span_up_c, span_dn_c, cross_c;

	// Count clamped to the table depth, and the status for the sequencer.
	always_comb begin
		if (32'(vertex_count_q) > pip_pkg::MAX_VERTICES) begin
			n_eff = pip_pkg::CNT_W'(pip_pkg::MAX_VERTICES);
		end else begin
			n_eff = vertex_count_q;
		end
		stat.cnt_zero = (n_eff == '0);
		stat.last_idx = pip_pkg::IDX_W'(n_eff - 1'b1);
		stat.out_full = out_valid_q;
	end

	assign slot_ok = (32'(vertex_index) < pip_pkg::MAX_VERTICES);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= '0;
		end else if (cfg_we) begin
			vertex_count_q <= cfg_wdata;
		end
	end

	// Table write and registered read.
	always_ff @(posedge clk) begin
		if (ctrl.wr_en && slot_ok) begin
			vtx_mem[pip_pkg::IDX_W'(vertex_index)] <= {coord_x, coord_y};
		end
		if (ctrl.rd_en) begin
			{bx_s1, by_s1} <= vtx_mem[ctrl.rd_addr];
		end
	end

	// Query point capture.
	always_ff @(posedge clk) begin
		if (ctrl.query_start) begin
			px_q <= coord_x;
			py_q <= coord_y;
		end
	end

	// Direction and y range of the current edge.
	assign up_c      = (by_s1 > ay_q);
	assign span_up_c = (py_q >= ay_q) && (py_q < by_s1);
	assign span_dn_c = (py_q < ay_q) && (py_q >= by_s1);

	// Stage one: previous vertex tracking and edge differences.
	always_ff @(posedge clk) begin
		if (load_s1 || edge_s1) begin
			ax_q <= bx_s1;
			ay_q <= by_s1;
		end
		if (edge_s1) begin
			dxp_s2  <= pip_pkg::DIFF_W'(px_q) - pip_pkg::DIFF_W'(ax_q);
			dy_s2   <= pip_pkg::DIFF_W'(by_s1) - pip_pkg::DIFF_W'(ay_q);
			dyp_s2  <= pip_pkg::DIFF_W'(py_q) - pip_pkg::DIFF_W'(ay_q);
			dbx_s2  <= pip_pkg::DIFF_W'(bx_s1) - pip_pkg::DIFF_W'(ax_q);
			up_s2   <= up_c;
			span_s2 <= up_c ? span_up_c : span_dn_c;
		end
	end

	// Stage two: the two cross products.
	always_ff @(posedge clk) begin
		if (edge_s2) begin
			lhs_s3  <= dxp_s2 * dy_s2;
			rhs_s3  <= dyp_s2 * dbx_s2;
			up_s3   <= up_s2;
			span_s3 <= span_s2;
		end
	end

	// Stage three: crossing decision.
	assign cross_c = span_s3 && (up_s3 ? (lhs_s3 <= rhs_s3) : (lhs_s3 >= rhs_s3));

	// Pipeline beat tags, parity and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_s1     <= 1'b0;
			edge_s1     <= 1'b0;
			edge_s2     <= 1'b0;
			edge_s3     <= 1'b0;
			parity_q    <= 1'b0;
			out_valid_q <= 1'b0;
			inside_q    <= 1'b0;
		end else begin
			load_s1 <= ctrl.load_prev;
			edge_s1 <= ctrl.edge_rd;
			edge_s2 <= edge_s1;
			edge_s3 <= edge_s2;
			if (ctrl.query_start) begin
				parity_q <= 1'b0;
			end else if (edge_s3 && cross_c) begin
				parity_q <= !parity_q;
			end
			if (ctrl.out_load) begin
				out_valid_q <= 1'b1;
				inside_q    <= parity_q;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign inside_res = inside_q;

endmodule

### design/point_in_polygon_test.sv
// ----------------------------------------------------------------------------
// point_in_polygon_test: even-odd point-in-polygon test
// A write beat stores one vertex; a query beat returns one beat that says
// whether the point lies inside the polygon formed by the first vertex_count
// table entries. A query with vertex_count zero goes straight to the result
// and answers outside; otherwise the walk reads n table entries, n being
// vertex_count capped at the table depth of 64: the single read port of the
// vertex table delivers one edge per cycle, and a three-stage difference,
// product and compare pipe follows it. The input is stalled while a query
// runs; a finished result waits in the output register while writes and the
// next query go on.
// ----------------------------------------------------------------------------
module point_in_polygon_test (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pip_pkg::CNT_W-1:0]           cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                cmd,
	input  logic [pip_pkg::SLOT_W-1:0]          vertex_index,
	input  logic signed [pip_pkg::COORD_W-1:0]  coord_x,
	input  logic signed [pip_pkg::COORD_W-1:0]  coord_y,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                inside_res
);

	pip_pkg::ctrl_t ctrl;
	pip_pkg::stat_t stat;

	// Sequencer.
	pip_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.cmd       (cmd),
		.out_stall (out_stall),
		.stat      (stat),
		.in_stall  (in_stall),
		.ctrl      (ctrl)
	);

	// Vertex table and crossing pipe.
	pip_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.vertex_index (vertex_index),
		.coord_x      (coord_x),
		.coord_y      (coord_y),
		.out_stall    (out_stall),
		.ctrl         (ctrl),
		.stat         (stat),
		.out_valid    (out_valid),
		.inside_res   (inside_res)
	);

endmodule
